### src/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Shared types, constants and the byte-wide CRC-16/MODBUS update used by
// the response frame checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rfc_pkg;

    localparam int unsigned POS_W     = 4;
    localparam int unsigned FRAME_LEN = 9;
    localparam int unsigned CRC_SPAN  = 7;

    localparam logic [POS_W-1:0] POS_IDLE   = 4'd9;
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] POS_CRC_HI = 4'd7;
    localparam logic [POS_W-1:0] POS_VAL_B0 = 4'd3;
    localparam logic [POS_W-1:0] POS_VAL_B1 = 4'd4;
    localparam logic [POS_W-1:0] POS_VAL_B2 = 4'd5;
    localparam logic [POS_W-1:0] POS_VAL_B3 = 4'd6;
    localparam logic [POS_W-1:0] POS_SPAN   = POS_W'(CRC_SPAN);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_rfc_in;

    typedef struct packed {
        logic [31:0] value_bits;
        logic [15:0] crc_computed;
        logic [15:0] crc_received;
        logic        crc_ok;
    } t_rfc_out;

    // One byte through the reflected CRC: eight shift/xor steps.
    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### src/rfc_frame_proc.sv
// ----------------------------------------------------------------------------
// rfc_frame_proc
// Frame tracking state and per-byte processing: position, CRC accumulator,
// value word and received CRC high byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_frame_proc (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire rfc_pkg::t_rfc_in  i_item,
    output logic                   o_res_vld,
    output rfc_pkg::t_rfc_out      o_res
);
    import rfc_pkg::*;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_crc, n_crc;
    logic [31:0]      r_word, n_word;
    logic [7:0]       r_hi, n_hi;

    logic [POS_W-1:0] pos;
    logic             active;
    logic [15:0]      crc_base;
    logic [31:0]      word_base;
    logic [7:0]       hi_base;
    logic [7:0]       b;

    always_comb begin
        b         = i_item.rx_byte;
        pos       = i_item.frame_start ? '0 : r_pos;
        active    = i_item.frame_start || (r_pos < POS_IDLE);
        crc_base  = i_item.frame_start ? CRC_INIT : r_crc;
        word_base = i_item.frame_start ? '0 : r_word;
        hi_base   = i_item.frame_start ? '0 : r_hi;

        n_crc  = (pos < POS_SPAN) ? crc_update(crc_base, b) : crc_base;
        n_word = word_base;
        case (pos)
            POS_VAL_B0: n_word = word_base | {24'h0, b};
            POS_VAL_B1: n_word = word_base | {16'h0, b, 8'h0};
            POS_VAL_B2: n_word = word_base | {8'h0, b, 16'h0};
            POS_VAL_B3: n_word = word_base | {b, 24'h0};
            default:    n_word = word_base;
        endcase
        n_hi  = (pos == POS_CRC_HI) ? b : hi_base;
        n_pos = (pos == POS_LAST) ? POS_IDLE : pos + 1'b1;

        o_res_vld           = active && (pos == POS_LAST);
        o_res.value_bits    = n_word;
        o_res.crc_computed  = n_crc;
        o_res.crc_received  = {hi_base, b};
        o_res.crc_ok        = (n_crc == {hi_base, b});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= POS_IDLE;
            r_crc  <= CRC_INIT;
            r_word <= '0;
            r_hi   <= '0;
        end else if (i_advance && active) begin
            r_pos  <= n_pos;
            r_crc  <= n_crc;
            r_word <= n_word;
            r_hi   <= n_hi;
        end
    end

endmodule

`default_nettype wire

### src/rfc_out_reg.sv
// ----------------------------------------------------------------------------
// rfc_out_reg
// Result register: holds a finished result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rfc_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire rfc_pkg::t_rfc_out  i_res,
    input  wire logic               i_stall,
    output logic                    o_free,
    output logic                    o_valid,
    output rfc_pkg::t_rfc_out       o_data
);
    import rfc_pkg::*;

    logic     r_vld;
    t_rfc_out r_data;

    assign o_free  = !r_vld || !i_stall;
    assign o_valid = r_vld;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    // Payload: load only; hold while stalled.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res;
        end
    end

endmodule

`default_nettype wire

### src/response_frame_checker_core.sv
// ----------------------------------------------------------------------------
// response_frame_checker_core
// Byte-serial checker for a 9-byte instrument response frame with a
// CRC-16/MODBUS trailer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_data): one received byte per
//   transfer, with frame_start set on byte 0 of each frame. A start always
//   restarts the frame; bytes outside a frame are dropped.
//   Output channel (o_valid / i_stall / o_data): one transfer per complete
//   frame, issued on byte 8, carrying the IEEE-754 value bits (bytes 6..3),
//   the CRC computed over bytes 0..6, the received CRC (byte 7 high, byte 8
//   low) and a match flag.
//   Throughput: one byte per cycle while no stall holds it. The per-byte CRC
//   update is one short combinational step between the input register and
//   the state/result registers.
//   Result path: byte 8 passes the input register, then the result register,
//   where o_valid rises once the result slot is free.
//   Reset (i_rst_n low, synchronous) empties both registers and returns the
//   frame tracker to waiting for a start.
//   Stall: while i_stall holds a result, the input register still advances
//   bytes that produce no result; a byte that would produce a new result
//   waits and o_stall rises until the receiver takes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module response_frame_checker_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire rfc_pkg::t_rfc_in   i_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output rfc_pkg::t_rfc_out       o_data
);
    import rfc_pkg::*;

    // Input register
    logic    r_in_vld;
    t_rfc_in r_in_data;

    logic     res_vld;
    t_rfc_out res;
    logic     out_free;
    logic     advance;
    logic     accept;

    // Advance the held byte when it makes no result or the result slot frees.
    assign advance = r_in_vld && (!res_vld || out_free);
    assign o_stall = r_in_vld && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_data <= i_data;
        end
    end

    rfc_frame_proc u_proc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_data),
        .o_res_vld (res_vld),
        .o_res     (res)
    );

    rfc_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && res_vld),
        .i_res   (res),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams into response_frame_checker_core: well-formed 9-byte
// frames with good and corrupted CRC trailers, cut-off frames, restarts,
// trailing and stray bytes. A byte-level model of the frame tracker
// predicts each frame result; a monitor compares every result transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rfc_pkg::*;

    localparam int unsigned CLK_PERIOD       = 10;
    localparam int unsigned RESET_CYCLES     = 7;
    localparam int unsigned RANDOM_PER_PHASE = 578;
    localparam int unsigned PRESSURE_CYCLES  = 400;
    localparam int unsigned DRAIN_CYCLES     = 12;
    localparam int unsigned CYCLE_LIMIT      = 300000;

    // Traffic shaping per phase: who idles and how often.
    typedef enum logic [1:0] {
        PHASE_RX_SLOW,
        PHASE_TX_SLOW,
        PHASE_FULL_RATE
    } t_traffic_phase;

    // How the two trailer bytes of a generated frame relate to its CRC.
    typedef enum logic [1:0] {
        TRAILER_GOOD,
        TRAILER_SWAPPED,
        TRAILER_BIT_FLIP,
        TRAILER_GARBAGE
    } t_trailer;

    // Shapes of random stimulus sequences.
    typedef enum logic [2:0] {
        SEQ_GOOD_FRAME,
        SEQ_BAD_FRAME,
        SEQ_CUT_FRAME,
        SEQ_STRAY_BYTES,
        SEQ_FRAME_TAIL
    } t_sequence;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_rfc_in   i_data  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_rfc_out  o_data;

    // Bytes waiting to be offered, and frame results the model predicts.
    t_rfc_in   byte_queue[$];
    t_rfc_out  expected_frames[$];

    // Frame tracker model state.
    logic [POS_W-1:0] model_pos     = POS_IDLE;
    logic [15:0]      model_crc     = CRC_INIT;
    logic [31:0]      model_word    = '0;
    logic [7:0]       model_crc_hi  = '0;

    t_traffic_phase   traffic_phase     = PHASE_RX_SLOW;
    int unsigned      sender_idle_pct   = 0;
    int unsigned      receiver_idle_pct = 0;
    int unsigned      counted_bytes     = 0;
    int unsigned      mismatch_count    = 0;
    int unsigned      cycle_count       = 0;
    int unsigned      hold_left         = 0;
    logic             pressure_done     = 1'b0;

    response_frame_checker_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Reflected CRC-16/MODBUS, one byte: xor in, then eight shift steps.
    function automatic logic [15:0] crc16_modbus_step(input logic [15:0] acc,
                                                      input logic [7:0]  data);
        logic [15:0] r;
        r = acc ^ {8'h00, data};
        repeat (8) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Advance the frame tracker by one accepted byte; on the last frame byte
    // push the predicted result.
    task automatic frame_model_step(input t_rfc_in item);
        t_rfc_out         verdict;
        logic [POS_W-1:0] pos;
        if (item.frame_start) begin
            // A start always opens a fresh frame, dropping any partial one.
            model_crc    = CRC_INIT;
            model_word   = '0;
            model_crc_hi = '0;
            pos          = '0;
        end else begin
            pos = model_pos;
            // Outside a frame: drop the byte, nothing changes.
            if (pos >= POS_IDLE) return;
        end
        if (pos < POS_SPAN) begin
            model_crc = crc16_modbus_step(model_crc, item.rx_byte);
        end
        if (pos >= POS_VAL_B0 && pos <= POS_VAL_B3) begin
            model_word = model_word | ({24'h0, item.rx_byte} << (8 * (pos - POS_VAL_B0)));
        end
        if (pos == POS_CRC_HI) begin
            model_crc_hi = item.rx_byte;
        end
        if (pos == POS_LAST) begin
            // Byte 7 is the high half of the received CRC, byte 8 the low half.
            verdict.value_bits   = model_word;
            verdict.crc_computed = model_crc;
            verdict.crc_received = {model_crc_hi, item.rx_byte};
            verdict.crc_ok       = (model_crc == {model_crc_hi, item.rx_byte});
            expected_frames.push_back(verdict);
            model_pos = POS_IDLE;
            return;
        end
        model_pos = pos + 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------

    // Bytes that the block merely drops do not count toward the item budget.
    task automatic queue_transfer(input logic [7:0] value, input logic start,
                                  input logic counted);
        t_rfc_in item;
        item.rx_byte     = value;
        item.frame_start = start;
        byte_queue.push_back(item);
        if (counted) counted_bytes++;
    endtask

    // Frame body bytes 0..6, leaning on the extremes now and then.
    function automatic logic [55:0] random_body();
        logic [55:0] body;
        for (int i = 0; i < 7; i++) begin
            case ($urandom_range(0, 9))
                0:       body[8*i +: 8] = 8'h00;
                1:       body[8*i +: 8] = 8'hFF;
                default: body[8*i +: 8] = 8'($urandom);
            endcase
        end
        return body;
    endfunction

    // Queue the first 'keep' bytes of a frame built from 'body' and a trailer.
    task automatic queue_frame(input logic [55:0] body, input t_trailer trailer,
                               input int unsigned keep);
        logic [7:0]  frame_bytes [9];
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int i = 0; i < 7; i++) begin
            frame_bytes[i] = body[8*i +: 8];
            crc = crc16_modbus_step(crc, frame_bytes[i]);
        end
        case (trailer)
            TRAILER_GOOD:     {frame_bytes[7], frame_bytes[8]} = crc;
            TRAILER_SWAPPED:  {frame_bytes[7], frame_bytes[8]} = {crc[7:0], crc[15:8]};
            TRAILER_BIT_FLIP: {frame_bytes[7], frame_bytes[8]} =
                                  crc ^ (16'h0001 << $urandom_range(0, 15));
            default:          {frame_bytes[7], frame_bytes[8]} = 16'($urandom);
        endcase
        for (int i = 0; i < keep; i++) begin
            queue_transfer(frame_bytes[i], i == 0, 1'b1);
        end
    endtask

    // Directed opening: stray byte before any frame, restart mid-frame,
    // all-zero frame with a good trailer, a dropped tail byte, an all-ones
    // frame, and a good frame whose CRC halves arrive in the wrong order.
    task automatic queue_directed();
        queue_transfer(8'hFF, 1'b0, 1'b0);
        queue_transfer(8'hA5, 1'b1, 1'b1);
        queue_transfer(8'h3C, 1'b0, 1'b1);
        queue_frame(56'h0, TRAILER_GOOD, 9);
        queue_transfer(8'h5A, 1'b0, 1'b0);
        for (int i = 0; i < 9; i++) begin
            queue_transfer(8'hFF, i == 0, 1'b1);
        end
        queue_frame(56'h80_3F_7F_00_11_22_33, TRAILER_SWAPPED, 9);
    endtask

    // Mostly well-formed frames with random content; the rest broken or noise.
    task automatic queue_random_frames(input int unsigned n_items);
        int unsigned target;
        int unsigned pick;
        t_sequence   shape;
        target = counted_bytes + n_items;
        while (counted_bytes < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      shape = SEQ_GOOD_FRAME;
            else if (pick < 70) shape = SEQ_BAD_FRAME;
            else if (pick < 82) shape = SEQ_CUT_FRAME;
            else if (pick < 90) shape = SEQ_STRAY_BYTES;
            else                shape = SEQ_FRAME_TAIL;
            case (shape)
                SEQ_GOOD_FRAME: queue_frame(random_body(), TRAILER_GOOD, 9);
                SEQ_BAD_FRAME:  queue_frame(random_body(),
                                            t_trailer'($urandom_range(1, 3)), 9);
                SEQ_CUT_FRAME:  queue_frame(random_body(),
                                            t_trailer'($urandom_range(0, 3)),
                                            $urandom_range(1, 8));
                SEQ_STRAY_BYTES: begin
                    repeat ($urandom_range(1, 3)) queue_transfer(8'($urandom), 1'b0, 1'b0);
                end
                default: begin
                    queue_frame(random_body(), TRAILER_GOOD, 9);
                    repeat ($urandom_range(1, 3)) queue_transfer(8'($urandom), 1'b0, 1'b0);
                end
            endcase
        end
    endtask

    task automatic wait_drained();
        while (byte_queue.size() != 0 || i_valid || expected_frames.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Input driver: offer queued bytes, hold a stalled byte, feed the model
    // with every transfer that completes at this edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_bytes
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                frame_model_step(i_data);
            end
            if (i_valid && o_stall) begin
                // Hold: payload and valid stay as they are.
            end else if (byte_queue.size() != 0 &&
                         $urandom_range(0, 99) >= sender_idle_pct) begin
                i_data  <= byte_queue.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off at the start of
    // the full-rate phase so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_result_stall
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (traffic_phase == PHASE_FULL_RATE && !pressure_done) begin
                hold_left     = PRESSURE_CYCLES;
                pressure_done = 1'b1;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result transfer with the oldest prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_rfc_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_frames.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %h", $time, o_data);
            end else begin
                want = expected_frames.pop_front();
                check_field("value_bits", want.value_bits, o_data.value_bits);
                check_field("crc_computed", {16'h0, want.crc_computed},
                            {16'h0, o_data.crc_computed});
                check_field("crc_received", {16'h0, want.crc_received},
                            {16'h0, o_data.crc_received});
                check_field("crc_ok", {31'h0, want.crc_ok}, {31'h0, o_data.crc_ok});
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing: reset, then three traffic phases, then drain and report.
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender mostly busy, receiver mostly stalling.
        @(negedge i_clk);
        traffic_phase     = PHASE_RX_SLOW;
        sender_idle_pct   = 17;
        receiver_idle_pct = 84;
        queue_directed();
        queue_random_frames(RANDOM_PER_PHASE);
        wait_drained();

        // Sender mostly idle, receiver mostly ready.
        @(negedge i_clk);
        traffic_phase     = PHASE_TX_SLOW;
        sender_idle_pct   = 84;
        receiver_idle_pct = 17;
        queue_random_frames(RANDOM_PER_PHASE);
        wait_drained();

        // No idling on either side; the receiver's long hold-off lands here.
        @(negedge i_clk);
        traffic_phase     = PHASE_FULL_RATE;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        queue_random_frames(RANDOM_PER_PHASE);
        wait_drained();

        // Give the two-stage pipeline time to show any stray result.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_frames.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
